// ===== hdl/sdfpd_pkg.sv =====
package sdfpd_pkg;

	// value widths: differences, squares, sums and roots
	localparam int VW    = 37;
	localparam int MW    = 34;
	localparam int SW    = 2 * MW;
	localparam int RW    = MW;
	localparam int NCELL = RW;
	localparam int AW    = 5;

	typedef logic signed [VW-1:0] val_t;

	// shape codes
	localparam logic [2:0] SHAPE_SPHERE = 3'd0;
	localparam logic [2:0] SHAPE_BOX    = 3'd1;
	localparam logic [2:0] SHAPE_RBOX   = 3'd2;
	localparam logic [2:0] SHAPE_TORUS  = 3'd3;
	localparam logic [2:0] SHAPE_CYL    = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SHAPE  = 3'd0;
	localparam logic [2:0] REG_CX     = 3'd1;
	localparam logic [2:0] REG_CY     = 3'd2;
	localparam logic [2:0] REG_CZ     = 3'd3;
	localparam logic [2:0] REG_SX     = 3'd4;
	localparam logic [2:0] REG_SY     = 3'd5;
	localparam logic [2:0] REG_SZ     = 3'd6;
	localparam logic [2:0] REG_RADIUS = 3'd7;

	localparam val_t DIST_MAX = 37'sd2147483647;
	localparam val_t DIST_MIN = -37'sd2147483648;

	typedef struct packed {
		logic [2:0]         shape;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        sx;
		logic [30:0]        sy;
		logic [30:0]        sz;
		logic [30:0]        rad;
	} cfg_t;

	// values that travel beside a norm
	typedef struct packed {
		logic [2:0] shape;
		val_t       dy;
		val_t       qy;
		val_t       bias;
		val_t       r1;
	} side_t;

	function automatic val_t vmax(input val_t a, input val_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic val_t vmin(input val_t a, input val_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic val_t vabs(input val_t a);
		return (a < 0) ? -a : a;
	endfunction

endpackage

// ===== hdl/sdfpd_if.sv =====
interface sdfpd_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sdfpd_dist_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] distance;
	logic               saturated;
	modport source (output valid, distance, saturated, input ready);
	modport sink (input valid, distance, saturated, output ready);
endinterface

// ===== hdl/sdf_primitive_distance_unit.sv =====
// Signed distance from a query point to one configured primitive.
// Channels: pnt takes one word per point (point_x/y/z, signed Q16.16);
// result returns one word per point (distance, saturated) in input order.
// The APB port writes shape, center, sizes and radius; it must only be
// written while no point is in flight.
// Pipeline: one entry stage, two norm units of 36 stages each (square,
// sum, 34 root cells), one stage between them and one output register.
// Throughput: one point per cycle unless the output stalls; every stage
// of the cell chains advances together, so the rate is set by the
// pipeline, not by the root. When the receiver stalls with a word waiting
// in the output register the whole pipeline holds and pnt.ready drops;
// nothing is lost. Reset clears all valid bits and the registers to zero
// (sphere of radius zero at the origin); no clearing pass is needed.
module sdf_primitive_distance_unit import sdfpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	sdfpd_point_if.sink   pnt,
	sdfpd_dist_if.source  result
);
	cfg_t  cfg;
	logic  en;

	val_t  dx, dy, dz, qx, qy, qz, px, py, pz, bias1;
	val_t  a1, b1, c1;
	side_t side1;

	val_t  a1_s1, b1_s1, c1_s1;
	side_t side_s1;
	logic  v_s1;

	logic          n1_v;
	logic [RW-1:0] n1_root;
	side_t         n1_side;
	val_t          r1, t, a2, b2;
	side_t         side2;

	val_t  a2_s2, b2_s2;
	side_t side_s2;
	logic  v_s2;

	logic          n2_v;
	logic [RW-1:0] n2_root;
	side_t         n2_side;
	val_t          r2, dval;

	logic               v_s3;
	logic signed [31:0] dist_s3;
	logic               sat_s3;

	sdfpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance unless a word waits in the output register
	assign en        = !v_s3 || result.ready;
	assign pnt.ready = en;

	// offsets and box terms
	always_comb begin
		dx = val_t'(pnt.point_x) - val_t'(cfg.cx);
		dy = val_t'(pnt.point_y) - val_t'(cfg.cy);
		dz = val_t'(pnt.point_z) - val_t'(cfg.cz);
		qx = vabs(dx) - val_t'(cfg.sx);
		qy = vabs(dy) - val_t'(cfg.sy);
		qz = vabs(dz) - val_t'(cfg.sz);
		px = vmax(qx, '0);
		py = vmax(qy, '0);
		pz = vmax(qz, '0);
		bias1 = vmin(vmax(qx, vmax(qy, qz)), '0);
		a1 = '0;
		b1 = '0;
		c1 = '0;
		unique case (cfg.shape)
			SHAPE_SPHERE: begin
				a1 = dx; b1 = dy; c1 = dz;
			end
			SHAPE_BOX, SHAPE_RBOX: begin
				a1 = px; b1 = py; c1 = pz;
			end
			SHAPE_TORUS, SHAPE_CYL: begin
				a1 = dx; b1 = dz;
			end
			default: ;
		endcase
		side1.shape = cfg.shape;
		side1.dy    = dy;
		side1.qy    = qy;
		side1.bias  = bias1;
		side1.r1    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pnt.valid;
			v_s2 <= n1_v;
			v_s3 <= n2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1   <= a1;
			b1_s1   <= b1;
			c1_s1   <= c1;
			side_s1 <= side1;
		end
	end

	sdfpd_norm u_norm1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_s1),
		.a      (a1_s1),
		.b      (b1_s1),
		.c      (c1_s1),
		.side_i (side_s1),
		.v_o    (n1_v),
		.root   (n1_root),
		.side_o (n1_side)
	);

	// second norm operands for torus and cylinder
	always_comb begin
		r1 = val_t'(n1_root);
		t  = r1 - val_t'(cfg.sx);
		a2 = '0;
		b2 = '0;
		side2    = n1_side;
		side2.r1 = r1;
		unique case (n1_side.shape)
			SHAPE_TORUS: begin
				a2 = t; b2 = n1_side.dy;
			end
			SHAPE_CYL: begin
				a2 = vmax(t, '0);
				b2 = vmax(n1_side.qy, '0);
				side2.bias = vmin(vmax(t, n1_side.qy), '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s2   <= a2;
			b2_s2   <= b2;
			side_s2 <= side2;
		end
	end

	sdfpd_norm u_norm2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_s2),
		.a      (a2_s2),
		.b      (b2_s2),
		.c      ('0),
		.side_i (side_s2),
		.v_o    (n2_v),
		.root   (n2_root),
		.side_o (n2_side)
	);

	// combine per shape
	always_comb begin
		r2 = val_t'(n2_root);
		unique case (n2_side.shape)
			SHAPE_SPHERE, SHAPE_RBOX: dval = n2_side.r1 - val_t'(cfg.rad);
			SHAPE_BOX:                dval = n2_side.bias + n2_side.r1;
			SHAPE_TORUS:              dval = r2 - val_t'(cfg.sy);
			SHAPE_CYL:                dval = n2_side.bias + r2;
			default:                  dval = '0;
		endcase
	end

	// clip and hold the result word
	always_ff @(posedge clk) begin
		if (en) begin
			if (dval > DIST_MAX) begin
				dist_s3 <= DIST_MAX[31:0];
				sat_s3  <= 1'b1;
			end else if (dval < DIST_MIN) begin
				dist_s3 <= DIST_MIN[31:0];
				sat_s3  <= 1'b1;
			end else begin
				dist_s3 <= dval[31:0];
				sat_s3  <= 1'b0;
			end
		end
	end

	assign result.valid     = v_s3;
	assign result.distance  = dist_s3;
	assign result.saturated = sat_s3;

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |->
			result.distance == 32'sh7fffffff || result.distance == 32'sh80000000)
		else $error("saturated result off the rails");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pnt.ready)
		else $error("input taken while output stalled");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && cfg.shape > SHAPE_CYL |->
			result.distance == 32'sd0 && !result.saturated)
		else $error("unknown shape gave nonzero distance");
endmodule

// ===== hdl/sdfpd_regs.sv =====
module sdfpd_regs import sdfpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output cfg_t          cfg
);
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[AW-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_SHAPE:  cfg.shape <= pwdata[2:0];
				REG_CX:     cfg.cx    <= pwdata;
				REG_CY:     cfg.cy    <= pwdata;
				REG_CZ:     cfg.cz    <= pwdata;
				REG_SX:     cfg.sx    <= pwdata[30:0];
				REG_SY:     cfg.sy    <= pwdata[30:0];
				REG_SZ:     cfg.sz    <= pwdata[30:0];
				REG_RADIUS: cfg.rad   <= pwdata[30:0];
				default:    ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_SHAPE:  prdata = {29'd0, cfg.shape};
			REG_CX:     prdata = cfg.cx;
			REG_CY:     prdata = cfg.cy;
			REG_CZ:     prdata = cfg.cz;
			REG_SX:     prdata = {1'b0, cfg.sx};
			REG_SY:     prdata = {1'b0, cfg.sy};
			REG_SZ:     prdata = {1'b0, cfg.sz};
			REG_RADIUS: prdata = {1'b0, cfg.rad};
			default:    prdata = '0;
		endcase
	end
endmodule

// ===== hdl/sdfpd_sqrt_cell.sv =====
module sdfpd_sqrt_cell import sdfpd_pkg::*; #(
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [SW-1:0] x_i,
	input  logic [SW-1:0] res_i,
	input  side_t         side_i,
	output logic          v_o,
	output logic [SW-1:0] x_o,
	output logic [SW-1:0] res_o,
	output side_t         side_o
);
	localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

	logic [SW-1:0] trial;
	logic          take;

	// try one root bit against the remainder
	assign trial = res_i + BIT;
	assign take  = x_i >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	// hand remainder and partial root to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			x_o    <= take ? (x_i - trial) : x_i;
			res_o  <= take ? ((res_i >> 1) + BIT) : (res_i >> 1);
			side_o <= side_i;
		end
	end
endmodule

// ===== hdl/sdfpd_norm.sv =====
module sdfpd_norm import sdfpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  val_t          a,
	input  val_t          b,
	input  val_t          c,
	input  side_t         side_i,
	output logic          v_o,
	output logic [RW-1:0] root,
	output side_t         side_o
);
	val_t          abs_a, abs_b, abs_c;
	logic [MW-1:0] ma, mb, mc;
	logic [SW-1:0] sqa_s1, sqb_s1, sqc_s1, sum_s2;
	logic          v_s1, v_s2;
	side_t         side_s1, side_s2;

	logic [SW-1:0] x_c   [NCELL+1];
	logic [SW-1:0] res_c [NCELL+1];
	logic          v_c   [NCELL+1];
	side_t         side_c [NCELL+1];

	assign abs_a = vabs(a);
	assign abs_b = vabs(b);
	assign abs_c = vabs(c);
	assign ma = abs_a[MW-1:0];
	assign mb = abs_b[MW-1:0];
	assign mc = abs_c[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	// square, then sum
	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1  <= SW'(ma) * SW'(ma);
			sqb_s1  <= SW'(mb) * SW'(mb);
			sqc_s1  <= SW'(mc) * SW'(mc);
			side_s1 <= side_i;
			sum_s2  <= sqa_s1 + sqb_s1 + sqc_s1;
			side_s2 <= side_s1;
		end
	end

	assign x_c[0]    = sum_s2;
	assign res_c[0]  = '0;
	assign v_c[0]    = v_s2;
	assign side_c[0] = side_s2;

	// one root bit per cell, top bit first
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		sdfpd_sqrt_cell #(.K(NCELL - 1 - i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v_c[i]),
			.x_i    (x_c[i]),
			.res_i  (res_c[i]),
			.side_i (side_c[i]),
			.v_o    (v_c[i+1]),
			.x_o    (x_c[i+1]),
			.res_o  (res_c[i+1]),
			.side_o (side_c[i+1])
		);
	end

	assign v_o    = v_c[NCELL];
	assign root   = res_c[NCELL][RW-1:0];
	assign side_o = side_c[NCELL];
endmodule
